// ----- rtl/cpu6502eu_pkg.sv -----
// Package for the 6502-style execute unit: operation codes, status flag
// bit positions and field widths. No dependencies.
package cpu6502eu_pkg;

  localparam int unsigned OpW   = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned ExtW  = 2;

  // operation codes
  localparam logic [OpW-1:0] OpTax = 6'd0;
  localparam logic [OpW-1:0] OpTay = 6'd1;
  localparam logic [OpW-1:0] OpTxa = 6'd2;
  localparam logic [OpW-1:0] OpTya = 6'd3;
  localparam logic [OpW-1:0] OpTsx = 6'd4;
  localparam logic [OpW-1:0] OpTxs = 6'd5;
  localparam logic [OpW-1:0] OpPha = 6'd6;
  localparam logic [OpW-1:0] OpPhp = 6'd7;
  localparam logic [OpW-1:0] OpPla = 6'd8;
  localparam logic [OpW-1:0] OpPlp = 6'd9;
  localparam logic [OpW-1:0] OpAnd = 6'd10;
  localparam logic [OpW-1:0] OpEor = 6'd11;
  localparam logic [OpW-1:0] OpOra = 6'd12;
  localparam logic [OpW-1:0] OpBit = 6'd13;
  localparam logic [OpW-1:0] OpAdc = 6'd14;
  localparam logic [OpW-1:0] OpSbc = 6'd15;
  localparam logic [OpW-1:0] OpCmp = 6'd16;
  localparam logic [OpW-1:0] OpCpx = 6'd17;
  localparam logic [OpW-1:0] OpCpy = 6'd18;
  localparam logic [OpW-1:0] OpInc = 6'd19;
  localparam logic [OpW-1:0] OpInx = 6'd20;
  localparam logic [OpW-1:0] OpIny = 6'd21;
  localparam logic [OpW-1:0] OpDec = 6'd22;
  localparam logic [OpW-1:0] OpDex = 6'd23;
  localparam logic [OpW-1:0] OpDey = 6'd24;
  localparam logic [OpW-1:0] OpBcc = 6'd25;
  localparam logic [OpW-1:0] OpBcs = 6'd26;
  localparam logic [OpW-1:0] OpBeq = 6'd27;
  localparam logic [OpW-1:0] OpBmi = 6'd28;
  localparam logic [OpW-1:0] OpBne = 6'd29;
  localparam logic [OpW-1:0] OpBpl = 6'd30;
  localparam logic [OpW-1:0] OpBvc = 6'd31;
  localparam logic [OpW-1:0] OpBvs = 6'd32;
  localparam logic [OpW-1:0] OpClc = 6'd33;
  localparam logic [OpW-1:0] OpCld = 6'd34;
  localparam logic [OpW-1:0] OpCli = 6'd35;
  localparam logic [OpW-1:0] OpClv = 6'd36;
  localparam logic [OpW-1:0] OpSec = 6'd37;
  localparam logic [OpW-1:0] OpSed = 6'd38;
  localparam logic [OpW-1:0] OpSei = 6'd39;
  localparam logic [OpW-1:0] OpNop = 6'd40;

  // status bit positions: N V - B D I Z C
  localparam int unsigned FlC = 0;
  localparam int unsigned FlZ = 1;
  localparam int unsigned FlI = 2;
  localparam int unsigned FlD = 3;
  localparam int unsigned FlB = 4;
  localparam int unsigned FlV = 6;
  localparam int unsigned FlN = 7;

  localparam logic [ByteW-1:0] StackPage = 8'h01;  // high byte of stack slots

  localparam logic [ExtW-1:0] ExtNone  = 2'd0;
  localparam logic [ExtW-1:0] ExtTaken = 2'd1;
  localparam logic [ExtW-1:0] ExtPage  = 2'd2;

endpackage

// ----- rtl/cpu6502_execute_unit.sv -----
// Execute stage of a 6502-style processor: A, X, Y, SP and status registers,
// ALU, compares, stack push/pull and branch target logic. Uses cpu6502eu_pkg.
//
// One beat in gives one beat out. A beat is first captured in an input
// register; from there one pass of combinational logic (one 8-bit add or
// logic op with flag update, plus a 16-bit branch add) updates the register
// file and loads the result register. Throughput is one beat per cycle while
// the result side does not stall; a beat passes through the input register
// and then the result register before it is shown. The register file is
// updated when a beat moves from the input register to the result register,
// so the next beat always sees the state left by the previous one. Pushes
// report a write to 0x0100 + SP (pre-decrement), INC/DEC report a write to
// operand_address; pulls take their byte on operand_byte. ADC/SBC are
// binary only, D is just a stored bit. Branches treat operand_byte as a
// signed displacement from next_pc and report ExtTaken on extra_cycles when
// taken, ExtPage when the target is on another page. Codes above NOP act as NOP.
module cpu6502_execute_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [cpu6502eu_pkg::OpW-1:0]          operation_i,
  input  logic [cpu6502eu_pkg::ByteW-1:0]        operand_byte_i,
  input  logic [cpu6502eu_pkg::AddrW-1:0]        operand_address_i,
  input  logic [cpu6502eu_pkg::AddrW-1:0]        next_pc_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [cpu6502eu_pkg::ByteW-1:0]        acc_out_o,
  output logic [cpu6502eu_pkg::ByteW-1:0]        x_out_o,
  output logic [cpu6502eu_pkg::ByteW-1:0]        y_out_o,
  output logic [cpu6502eu_pkg::ByteW-1:0]        sp_out_o,
  output logic [cpu6502eu_pkg::ByteW-1:0]        status_out_o,
  output logic                                   write_enable_o,
  output logic [cpu6502eu_pkg::AddrW-1:0]        write_address_o,
  output logic [cpu6502eu_pkg::ByteW-1:0]        write_data_o,
  output logic [cpu6502eu_pkg::AddrW-1:0]        pc_out_o,
  output logic [cpu6502eu_pkg::ExtW-1:0]         extra_cycles_o
);
  import cpu6502eu_pkg::*;

  // ---------------------------------------------------------------------
  // Flow control: input register feeds the result register.
  // ---------------------------------------------------------------------
  logic             s1_valid_q;
  logic [OpW-1:0]   s1_op_q;
  logic [ByteW-1:0] s1_m_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [AddrW-1:0] s1_npc_q;

  logic out_free;   // result register can load this cycle
  logic s1_adv;     // beat in input register moves to result register
  logic in_acc;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= operation_i;
      s1_m_q    <= operand_byte_i;
      s1_addr_q <= operand_address_i;
      s1_npc_q  <= next_pc_i;
    end
  end

  // ---------------------------------------------------------------------
  // Architectural registers
  // ---------------------------------------------------------------------
  logic [ByteW-1:0] a_q, a_d;
  logic [ByteW-1:0] x_q, x_d;
  logic [ByteW-1:0] y_q, y_d;
  logic [ByteW-1:0] sp_q, sp_d;
  logic [ByteW-1:0] p_q, p_d;

  // per-beat outputs
  logic             we_d;
  logic [AddrW-1:0] wa_d;
  logic [ByteW-1:0] wd_d;
  logic [AddrW-1:0] pc_d;
  logic [ExtW-1:0]  ext_d;

  // shared datapath pieces
  logic [ByteW:0]   sum9;       // ADC/SBC with carry out
  logic [ByteW-1:0] add_m;
  logic [ByteW-1:0] cmp_r;
  logic [ByteW:0]   cmp_diff;   // bit 8 set means borrow
  logic [ByteW-1:0] rmw;        // INC/DEC result
  logic [AddrW-1:0] br_target;
  logic             br_cond;
  logic             is_branch;
  logic [ByteW-1:0] zn_val;
  logic             set_zn;

  always_comb begin
    add_m = (s1_op_q == OpSbc) ? ~s1_m_q : s1_m_q;
    sum9  = {1'b0, a_q} + {1'b0, add_m} + {{ByteW{1'b0}}, p_q[FlC]};

    case (s1_op_q)
      OpCpx:   cmp_r = x_q;
      OpCpy:   cmp_r = y_q;
      default: cmp_r = a_q;
    endcase
    cmp_diff = {1'b0, cmp_r} - {1'b0, s1_m_q};

    rmw = (s1_op_q == OpInc) ? s1_m_q + 8'd1 : s1_m_q - 8'd1;

    br_target = s1_npc_q + {{(AddrW-ByteW){s1_m_q[ByteW-1]}}, s1_m_q};
  end

  always_comb begin
    a_d       = a_q;
    x_d       = x_q;
    y_d       = y_q;
    sp_d      = sp_q;
    p_d       = p_q;
    we_d      = 1'b0;
    wa_d      = '0;
    wd_d      = '0;
    is_branch = 1'b0;
    br_cond   = 1'b0;
    zn_val    = '0;
    set_zn    = 1'b0;

    case (s1_op_q)
      OpTax: begin x_d = a_q;  zn_val = a_q;  set_zn = 1'b1; end
      OpTay: begin y_d = a_q;  zn_val = a_q;  set_zn = 1'b1; end
      OpTxa: begin a_d = x_q;  zn_val = x_q;  set_zn = 1'b1; end
      OpTya: begin a_d = y_q;  zn_val = y_q;  set_zn = 1'b1; end
      OpTsx: begin x_d = sp_q; zn_val = sp_q; set_zn = 1'b1; end
      OpTxs: begin sp_d = x_q; end
      OpPha, OpPhp: begin
        we_d = 1'b1;
        wa_d = {StackPage, sp_q};
        if (s1_op_q == OpPha) begin
          wd_d = a_q;
        end else begin
          wd_d = p_q;
          wd_d[FlB] = 1'b1;   // pushed copy only
        end
        sp_d = sp_q - 8'd1;
      end
      OpPla: begin
        sp_d   = sp_q + 8'd1;
        a_d    = s1_m_q;
        zn_val = s1_m_q;
        set_zn = 1'b1;
      end
      OpPlp: begin
        sp_d = sp_q + 8'd1;
        p_d  = s1_m_q;
      end
      OpAnd: begin a_d = a_q & s1_m_q; zn_val = a_q & s1_m_q; set_zn = 1'b1; end
      OpEor: begin a_d = a_q ^ s1_m_q; zn_val = a_q ^ s1_m_q; set_zn = 1'b1; end
      OpOra: begin a_d = a_q | s1_m_q; zn_val = a_q | s1_m_q; set_zn = 1'b1; end
      OpBit: begin
        p_d[FlZ] = ((a_q & s1_m_q) == '0);
        p_d[FlV] = s1_m_q[6];
        p_d[FlN] = s1_m_q[7];
      end
      OpAdc, OpSbc: begin
        p_d[FlV] = ~(a_q[7] ^ add_m[7]) & (a_q[7] ^ sum9[7]);
        p_d[FlC] = sum9[ByteW];
        a_d      = sum9[ByteW-1:0];
        zn_val   = sum9[ByteW-1:0];
        set_zn   = 1'b1;
      end
      OpCmp, OpCpx, OpCpy: begin
        p_d[FlC] = ~cmp_diff[ByteW];
        zn_val   = cmp_diff[ByteW-1:0];
        set_zn   = 1'b1;
      end
      OpInc, OpDec: begin
        we_d   = 1'b1;
        wa_d   = s1_addr_q;
        wd_d   = rmw;
        zn_val = rmw;
        set_zn = 1'b1;
      end
      OpInx: begin x_d = x_q + 8'd1; zn_val = x_q + 8'd1; set_zn = 1'b1; end
      OpIny: begin y_d = y_q + 8'd1; zn_val = y_q + 8'd1; set_zn = 1'b1; end
      OpDex: begin x_d = x_q - 8'd1; zn_val = x_q - 8'd1; set_zn = 1'b1; end
      OpDey: begin y_d = y_q - 8'd1; zn_val = y_q - 8'd1; set_zn = 1'b1; end
      OpBcc: begin is_branch = 1'b1; br_cond = ~p_q[FlC]; end
      OpBcs: begin is_branch = 1'b1; br_cond =  p_q[FlC]; end
      OpBeq: begin is_branch = 1'b1; br_cond =  p_q[FlZ]; end
      OpBmi: begin is_branch = 1'b1; br_cond =  p_q[FlN]; end
      OpBne: begin is_branch = 1'b1; br_cond = ~p_q[FlZ]; end
      OpBpl: begin is_branch = 1'b1; br_cond = ~p_q[FlN]; end
      OpBvc: begin is_branch = 1'b1; br_cond = ~p_q[FlV]; end
      OpBvs: begin is_branch = 1'b1; br_cond =  p_q[FlV]; end
      OpClc: p_d[FlC] = 1'b0;
      OpCld: p_d[FlD] = 1'b0;
      OpCli: p_d[FlI] = 1'b0;
      OpClv: p_d[FlV] = 1'b0;
      OpSec: p_d[FlC] = 1'b1;
      OpSed: p_d[FlD] = 1'b1;
      OpSei: p_d[FlI] = 1'b1;
      OpNop: ;
      default: ;  // unused codes behave as NOP
    endcase

    if (set_zn) begin
      p_d[FlZ] = (zn_val == '0);
      p_d[FlN] = zn_val[ByteW-1];
    end

    // branch resolution: ExtTaken when taken, ExtPage on a page change
    if (is_branch && br_cond) begin
      pc_d  = br_target;
      ext_d = (br_target[AddrW-1:ByteW] != s1_npc_q[AddrW-1:ByteW]) ? ExtPage : ExtTaken;
    end else begin
      pc_d  = s1_npc_q;
      ext_d = ExtNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      x_q  <= '0;
      y_q  <= '0;
      sp_q <= '0;
      p_q  <= '0;
    end else if (s1_adv) begin
      a_q  <= a_d;
      x_q  <= x_d;
      y_q  <= y_d;
      sp_q <= sp_d;
      p_q  <= p_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      acc_out_o       <= a_d;
      x_out_o         <= x_d;
      y_out_o         <= y_d;
      sp_out_o        <= sp_d;
      status_out_o    <= p_d;
      write_enable_o  <= we_d;
      write_address_o <= wa_d;
      write_data_o    <= wd_d;
      pc_out_o        <= pc_d;
      extra_cycles_o  <= ext_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- bench/cpu6502_execute_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the 6502-style execute unit: a scoreboard class
// predicts registers, write-back, PC and extra cycles per beat.
// Depends on rtl/cpu6502eu_pkg.sv and rtl/cpu6502_execute_unit.sv.
module cpu6502_execute_unit_tb;
  import cpu6502eu_pkg::*;

  localparam int unsigned RandomBeats  = 1800;
  localparam int unsigned PhaseBeats   = 300;   // receiver/sender pattern changes this often
  localparam int unsigned DrainAt      = 900;   // sender holds off here until all results land
  localparam int unsigned IdleLimit    = 5000;  // cycles with no handshake on either side
  localparam int unsigned TailCycles   = 8;     // input and result registers plus margin

  localparam logic [OpW-1:0] OpLastUnused = 6'd63;  // highest unused code, acts as NOP

  // One result beat, field order matches the port list of the block.
  typedef struct packed {
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] sp;
    logic [ByteW-1:0] status;
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic [AddrW-1:0] pc;
    logic [ExtW-1:0]  extra;
  } exec_result_t;

  // Scoreboard: mirrors the register file and holds the predicted result beats.
  class exec_scoreboard;
    logic [ByteW-1:0] acc, idx_x, idx_y, sp, flags;
    exec_result_t     pending_results[$];
    int unsigned      errors;

    function new();
      acc    = '0;
      idx_x  = '0;
      idx_y  = '0;
      sp     = '0;
      flags  = '0;
      errors = 0;
    endfunction

    function void set_zn(logic [ByteW-1:0] v);
      flags[FlZ] = (v == '0);
      flags[FlN] = v[7];
    endfunction

    // Binary add with carry in; SBC comes here with the operand inverted.
    function void add_to_acc(logic [ByteW-1:0] m);
      logic [ByteW:0] sum;
      sum = {1'b0, acc} + {1'b0, m} + {{ByteW{1'b0}}, flags[FlC]};
      flags[FlV] = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
      flags[FlC] = sum[ByteW];
      acc = sum[ByteW-1:0];
      set_zn(acc);
    endfunction

    function void compare_to(logic [ByteW-1:0] r, logic [ByteW-1:0] m);
      logic [ByteW-1:0] diff;
      diff = r - m;
      flags[FlC] = (r >= m);
      set_zn(diff);
    endfunction

    // Accepted input beat: update the mirrored state and queue the prediction.
    function void note_beat(logic [OpW-1:0] op, logic [ByteW-1:0] m,
                            logic [AddrW-1:0] addr, logic [AddrW-1:0] npc);
      exec_result_t     r;
      logic             taken;
      logic [ByteW-1:0] bumped;
      logic [AddrW-1:0] target;
      r     = '0;
      taken = 1'b0;
      r.pc  = npc;
      case (op)
        OpTax: begin idx_x = acc; set_zn(idx_x); end
        OpTay: begin idx_y = acc; set_zn(idx_y); end
        OpTxa: begin acc = idx_x; set_zn(acc); end
        OpTya: begin acc = idx_y; set_zn(acc); end
        OpTsx: begin idx_x = sp; set_zn(idx_x); end
        OpTxs: sp = idx_x;
        OpPha, OpPhp: begin
          // push reports the slot before the decrement; pushed status has B set
          r.we    = 1'b1;
          r.waddr = {StackPage, sp};
          r.wdata = (op == OpPha) ? acc : (flags | (8'h01 << FlB));
          sp      = sp - 8'd1;
        end
        OpPla: begin sp = sp + 8'd1; acc = m; set_zn(acc); end
        OpPlp: begin sp = sp + 8'd1; flags = m; end
        OpAnd: begin acc = acc & m; set_zn(acc); end
        OpEor: begin acc = acc ^ m; set_zn(acc); end
        OpOra: begin acc = acc | m; set_zn(acc); end
        OpBit: begin
          flags[FlZ] = ((acc & m) == '0);
          flags[FlV] = m[6];
          flags[FlN] = m[7];
        end
        OpAdc: add_to_acc(m);
        OpSbc: add_to_acc(~m);
        OpCmp: compare_to(acc, m);
        OpCpx: compare_to(idx_x, m);
        OpCpy: compare_to(idx_y, m);
        OpInc, OpDec: begin
          bumped  = (op == OpInc) ? m + 8'd1 : m - 8'd1;
          r.we    = 1'b1;
          r.waddr = addr;
          r.wdata = bumped;
          set_zn(bumped);
        end
        OpInx: begin idx_x = idx_x + 8'd1; set_zn(idx_x); end
        OpIny: begin idx_y = idx_y + 8'd1; set_zn(idx_y); end
        OpDex: begin idx_x = idx_x - 8'd1; set_zn(idx_x); end
        OpDey: begin idx_y = idx_y - 8'd1; set_zn(idx_y); end
        OpBcc: taken = ~flags[FlC];
        OpBcs: taken =  flags[FlC];
        OpBeq: taken =  flags[FlZ];
        OpBmi: taken =  flags[FlN];
        OpBne: taken = ~flags[FlZ];
        OpBpl: taken = ~flags[FlN];
        OpBvc: taken = ~flags[FlV];
        OpBvs: taken =  flags[FlV];
        OpClc: flags[FlC] = 1'b0;
        OpCld: flags[FlD] = 1'b0;
        OpCli: flags[FlI] = 1'b0;
        OpClv: flags[FlV] = 1'b0;
        OpSec: flags[FlC] = 1'b1;
        OpSed: flags[FlD] = 1'b1;
        OpSei: flags[FlI] = 1'b1;
        default: ;  // NOP and codes above it
      endcase
      if (taken) begin
        target  = npc + {{8{m[7]}}, m};
        r.pc    = target;
        r.extra = (target[15:8] != npc[15:8]) ? ExtPage : ExtTaken;
      end
      r.acc    = acc;
      r.x      = idx_x;
      r.y      = idx_y;
      r.sp     = sp;
      r.status = flags;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Accepted result beat: compare with the oldest prediction.
    function void check_beat(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing predicted, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      check_field("acc_out",       AddrW'(want.acc),    AddrW'(got.acc));
      check_field("x_out",         AddrW'(want.x),      AddrW'(got.x));
      check_field("y_out",         AddrW'(want.y),      AddrW'(got.y));
      check_field("sp_out",        AddrW'(want.sp),     AddrW'(got.sp));
      check_field("status_out",    AddrW'(want.status), AddrW'(got.status));
      check_field("write_enable",  AddrW'(want.we),     AddrW'(got.we));
      check_field("write_address", want.waddr,          got.waddr);
      check_field("write_data",    AddrW'(want.wdata),  AddrW'(got.wdata));
      check_field("pc_out",        want.pc,             got.pc);
      check_field("extra_cycles",  AddrW'(want.extra),  AddrW'(got.extra));
    endfunction
  endclass

  // Block ports; every input is known from time zero.
  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_stall_o;
  logic [OpW-1:0]   operation_i       = '0;
  logic [ByteW-1:0] operand_byte_i    = '0;
  logic [AddrW-1:0] operand_address_i = '0;
  logic [AddrW-1:0] next_pc_i         = '0;
  logic             out_valid_o;
  logic             out_stall_i       = 1'b0;
  logic [ByteW-1:0] acc_out_o, x_out_o, y_out_o, sp_out_o, status_out_o;
  logic             write_enable_o;
  logic [AddrW-1:0] write_address_o;
  logic [ByteW-1:0] write_data_o;
  logic [AddrW-1:0] pc_out_o;
  logic [ExtW-1:0]  extra_cycles_o;

  exec_scoreboard sb = new();

  int unsigned recv_mode    = 1;  // 0 never stall, 1 light, 2 heavy, 3 long runs
  int unsigned hold_cnt     = 0;
  logic        hold_stall   = 1'b0;
  int unsigned idle_cycles  = 0;

  cpu6502_execute_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .operand_byte_i    (operand_byte_i),
    .operand_address_i (operand_address_i),
    .next_pc_i         (next_pc_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .acc_out_o         (acc_out_o),
    .x_out_o           (x_out_o),
    .y_out_o           (y_out_o),
    .sp_out_o          (sp_out_o),
    .status_out_o      (status_out_o),
    .write_enable_o    (write_enable_o),
    .write_address_o   (write_address_o),
    .write_data_o      (write_data_o),
    .pc_out_o          (pc_out_o),
    .extra_cycles_o    (extra_cycles_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver stall pattern, updated on the falling edge.
  always @(negedge clk_i) begin
    case (recv_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: begin
        // alternate long stall runs with short free runs
        if (hold_cnt == 0) begin
          hold_stall = ~hold_stall;
          hold_cnt   = hold_stall ? $urandom_range(3, 20) : $urandom_range(1, 8);
        end else begin
          hold_cnt--;
        end
        out_stall_i <= hold_stall;
      end
    endcase
  end

  // Result monitor: every accepted result beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat({acc_out_o, x_out_o, y_out_o, sp_out_o, status_out_o, write_enable_o,
                     write_address_o, write_data_o, pc_out_o, extra_cycles_o});
    end
  end

  // Watchdog on handshake progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no handshake for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one beat from a falling edge, hold it until accepted, and return at
  // the next falling edge with valid still high.
  task automatic drive_beat(input logic [OpW-1:0] op, input logic [ByteW-1:0] m,
                            input logic [AddrW-1:0] addr, input logic [AddrW-1:0] npc);
    operation_i       = op;
    operand_byte_i    = m;
    operand_address_i = addr;
    next_pc_i         = npc;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(op, m, addr, npc);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Operand bytes lean toward the sign and carry boundaries.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return ByteW'($urandom());
    endcase
  endfunction

  // Addresses lean toward page edges so branches cross pages often.
  function automatic logic [AddrW-1:0] pick_addr();
    logic [ByteW-1:0] page;
    page = ByteW'($urandom());
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {page, 8'hFF};
      3:       return {page, 8'h00};
      4:       return {page, 8'h80};
      default: return AddrW'($urandom());
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    if ($urandom_range(0, 19) == 0) return OpW'($urandom_range(OpNop + 1, OpLastUnused));
    return OpW'($urandom_range(0, OpNop));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned next_phase;
    int unsigned burst;
    int unsigned gap_max;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: stack wrap both ways, pushed B bit, full status pull,
    // decimal flag ignored by ADC/SBC, overflow, compare edges, INC/DEC
    // wrap, a backward page-crossing branch, unknown code.
    drive_beat(OpPhp, 8'h00, 16'h0000, 16'h0000);  // SP 00 -> FF
    drive_beat(OpPha, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpPla, 8'h80, 16'h0000, 16'h0000);
    drive_beat(OpPla, 8'h00, 16'h0000, 16'h0000);  // SP FF -> 00
    drive_beat(OpPlp, 8'hFF, 16'h0000, 16'h0000);  // all flags set
    drive_beat(OpPhp, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpAdc, 8'hFF, 16'h0000, 16'h0000);  // D set, still binary
    drive_beat(OpSbc, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpCld, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpClc, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpAdc, 8'h7F, 16'h0000, 16'h0000);
    drive_beat(OpAdc, 8'h01, 16'h0000, 16'h0000);  // signed overflow
    drive_beat(OpSec, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpSbc, 8'h01, 16'h0000, 16'h0000);  // overflow the other way
    drive_beat(OpCmp, 8'h7F, 16'h0000, 16'h0000);
    drive_beat(OpCpx, 8'hFF, 16'h0000, 16'h0000);
    drive_beat(OpInc, 8'hFF, 16'hFFFF, 16'h0000);
    drive_beat(OpDec, 8'h00, 16'h0000, 16'hFFFF);
    drive_beat(OpBit, 8'hC0, 16'h0000, 16'h0000);
    drive_beat(OpClv, 8'h00, 16'h0000, 16'h0000);
    drive_beat(OpBvc, 8'h80, 16'h0000, 16'h0000);  // backward across 0000
    drive_beat(OpBcs, 8'h7F, 16'h0000, 16'hFFFF);  // not taken, C is clear after CPX
    drive_beat(OpBcc, 8'h10, 16'h0000, 16'h1234);  // taken, same page
    drive_beat(OpLastUnused, 8'hFF, 16'hFFFF, 16'hFFFF);
    drive_beat(OpNop, 8'hFF, 16'hFFFF, 16'hABCD);

    // Sweep every code once with random operands, then the random run.
    for (int op = 0; op < 64; op++) drive_beat(OpW'(op), pick_byte(), pick_addr(), pick_addr());

    sent       = 0;
    next_phase = 0;
    gap_max    = 0;
    while (sent < RandomBeats) begin
      if (sent >= next_phase) begin
        recv_mode  = $urandom_range(0, 3);
        gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        next_phase = next_phase + PhaseBeats;
      end
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        drive_beat(pick_op(), pick_byte(), pick_addr(), pick_addr());
        sent++;
        if (sent == DrainAt) begin
          // let the pipeline run dry before continuing
          in_valid_i = 1'b0;
          while (sb.pending_results.size() != 0) @(negedge clk_i);
        end
      end
      if (gap_max != 0) idle_sender($urandom_range(0, gap_max));
    end

    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
